FILE: rtl/core/idiv_pkg.sv
package idiv_pkg;

    // Width of the division itself and of the operand and result ports.
    localparam int DivW   = 64;
    localparam int FieldW = 64;

    // Number of stages from an accepted item to its result: one operand
    // stage, one stage per quotient bit and one sign fix-up stage.
    localparam int Latency = DivW + 2;

    // Everything that moves from one division stage to the next.
    typedef struct packed {
        logic            valid;
        logic [DivW-1:0] part;   // partial remainder
        logic [DivW-1:0] nq;     // dividend bits still to use, quotient bits shifted in below
        logic [DivW-1:0] den;    // divisor magnitude
        logic            neg_r;  // remainder takes a minus sign at the end
        logic            neg_q;  // quotient takes a minus sign at the end
    } t_stage;

endpackage

FILE: rtl/core/idiv_prep.sv
module idiv_prep (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [idiv_pkg::FieldW-1:0]  i_dividend,
    input  logic [idiv_pkg::FieldW-1:0]  i_divisor,
    input  logic                         i_signed_mode,
    output idiv_pkg::t_stage             o_stage
);
    import idiv_pkg::*;

    logic [DivW-1:0] w_n;
    logic [DivW-1:0] w_d;
    logic            w_neg_n;
    logic            w_neg_d;
    t_stage          n_stage;
    t_stage          r_stage;

    // All bits of each operand take part; the top bit is the sign in signed mode.
    assign w_n     = i_dividend[DivW-1:0];
    assign w_d     = i_divisor[DivW-1:0];
    assign w_neg_n = i_signed_mode & w_n[DivW-1];
    assign w_neg_d = i_signed_mode & w_d[DivW-1];

    // Take magnitudes and note which signs the results get.
    always_comb begin
        n_stage.valid = i_valid;
        n_stage.part  = '0;
        n_stage.nq    = w_neg_n ? (~w_n + DivW'(1)) : w_n;
        n_stage.den   = w_neg_d ? (~w_d + DivW'(1)) : w_d;
        n_stage.neg_r = w_neg_n;
        n_stage.neg_q = w_neg_n ^ w_neg_d;
    end

    // The valid bit is reset; the payload follows it without reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.part  <= n_stage.part;
        r_stage.nq    <= n_stage.nq;
        r_stage.den   <= n_stage.den;
        r_stage.neg_r <= n_stage.neg_r;
        r_stage.neg_q <= n_stage.neg_q;
    end

    assign o_stage = r_stage;

endmodule

FILE: rtl/core/idiv_step.sv
module idiv_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  idiv_pkg::t_stage i_stage,
    output idiv_pkg::t_stage o_stage
);
    import idiv_pkg::*;

    logic            w_carry;
    logic [DivW-1:0] w_shift;
    logic [DivW:0]   w_diff;
    logic            w_take;
    t_stage          n_stage;
    t_stage          r_stage;

    // Shift the next dividend bit into the partial remainder. The bit that
    // falls off the top is kept, so the trial subtraction is one bit wider.
    assign w_carry = i_stage.part[DivW-1];
    assign w_shift = {i_stage.part[DivW-2:0], i_stage.nq[DivW-1]};
    assign w_diff  = {w_carry, w_shift} - {1'b0, i_stage.den};
    assign w_take  = ~w_diff[DivW];

    // Keep the difference when it did not borrow and record a quotient bit.
    always_comb begin
        n_stage       = i_stage;
        n_stage.part  = w_take ? w_diff[DivW-1:0] : w_shift;
        n_stage.nq    = {i_stage.nq[DivW-2:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.part  <= n_stage.part;
        r_stage.nq    <= n_stage.nq;
        r_stage.den   <= n_stage.den;
        r_stage.neg_r <= n_stage.neg_r;
        r_stage.neg_q <= n_stage.neg_q;
    end

    assign o_stage = r_stage;

endmodule

FILE: rtl/core/idiv_fix.sv
module idiv_fix (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  idiv_pkg::t_stage             i_stage,
    output logic                         o_done,
    output logic [idiv_pkg::FieldW-1:0]  o_quotient,
    output logic [idiv_pkg::FieldW-1:0]  o_remainder
);
    import idiv_pkg::*;

    logic [DivW-1:0] n_quo;
    logic [DivW-1:0] n_rem;
    logic [DivW-1:0] r_quo;
    logic [DivW-1:0] r_rem;
    logic            r_done;

    // Apply the signs; everything wraps at the division width.
    assign n_quo = i_stage.neg_q ? (~i_stage.nq + DivW'(1)) : i_stage.nq;
    assign n_rem = i_stage.neg_r ? (~i_stage.part + DivW'(1)) : i_stage.part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_stage.valid;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    // Bits above the division width read as zero.
    assign o_done      = r_done;
    assign o_quotient  = FieldW'(r_quo);
    assign o_remainder = FieldW'(r_rem);

endmodule

FILE: rtl/core/int64_divider_with_remainder.sv
// Pipelined 64-bit divider with remainder, signed or unsigned. An item is
// taken at every clock edge with start high; busy never rises, so a new item
// may follow in each cycle. Each result appears on o_quotient and
// o_remainder for exactly one cycle with o_done high, once its item has
// passed the operand magnitude stage, each of the 64 restoring subtract
// stages and the sign fix-up stage. Results leave in the order items
// came in and cannot be held off. Signed division truncates toward zero
// and the remainder takes the dividend's sign; the most negative value
// over minus one gives itself with remainder zero. A zero divisor gives
// an all-ones magnitude quotient and the dividend as remainder, with the
// usual sign fix-up applied in signed mode.
module int64_divider_with_remainder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [idiv_pkg::FieldW-1:0]  i_dividend,
    input  logic [idiv_pkg::FieldW-1:0]  i_divisor,
    input  logic                         i_signed_mode,
    output logic                         o_done,
    output logic [idiv_pkg::FieldW-1:0]  o_quotient,
    output logic [idiv_pkg::FieldW-1:0]  o_remainder
);
    import idiv_pkg::*;

    t_stage w_stage [0:DivW];

    // The pipeline never stalls, so an item is always welcome.
    assign busy = 1'b0;

    // Operand magnitudes and sign flags.
    idiv_prep u_prep (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (start),
        .i_dividend    (i_dividend),
        .i_divisor     (i_divisor),
        .i_signed_mode (i_signed_mode),
        .o_stage       (w_stage[0])
    );

    // One restoring step per stage, most significant quotient bit first.
    for (genvar g = 0; g < DivW; g++) begin : g_step
        idiv_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    // Sign fix-up and result register.
    idiv_fix u_fix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (w_stage[DivW]),
        .o_done      (o_done),
        .o_quotient  (o_quotient),
        .o_remainder (o_remainder)
    );

endmodule
